>>> design/ngs_pkg.sv
// ----------------------------------------------------------------------------
// ngs_pkg
// Shared constants and types for the next-greater-element stack unit.
// ----------------------------------------------------------------------------
package ngs_pkg;

   localparam int STACK_DEPTH_DEFAULT = 63;
   localparam int POS_BITS_DEFAULT    = 16;
   localparam int QUEUE_DEPTH         = 4;

   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 16;
   localparam int STATUS_W   = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_FOUND    = 2'd0,
      STATUS_NONE     = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

endpackage

>>> design/next_greater_element_stack_top.sv
// Next-greater-element unit on a monotonic stack.
// Per item the sequencer reads the stack top, pops each smaller entry, then
// pushes the item or reports overflow; a final item then flushes the rest.
// Each pop or flush is a separate registered top read of the single-port stack
// memory. The sequencer takes the next item only when the last is done.
// Reset (synchronous): stack empty, position counter zero, queue empty.
// ----------------------------------------------------------------------------
// next_greater_element_stack_top
// Front tags items with positions, a queue decouples it from the stack
// sequencer, which produces the answer transactions.
// ----------------------------------------------------------------------------
module next_greater_element_stack_top
   import ngs_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
   parameter int POS_BITS    = POS_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_final_item,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [POSITION_W-1:0]     rsp_position,
   output logic signed [VALUE_W-1:0] rsp_next_greater,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic                      rsp_run_end
);

   localparam int ITEM_W = VALUE_W + POS_BITS + 1;

   logic              queue_full;
   logic              queue_write;
   logic [ITEM_W-1:0] queue_wdata;
   logic              queue_valid;
   logic              queue_read;
   logic [ITEM_W-1:0] queue_rdata;

   ngs_front #(
      .POS_BITS (POS_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_final_item (req_final_item),
      .queue_full     (queue_full),
      .queue_write    (queue_write),
      .queue_data     (queue_wdata)
   );

   ngs_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .write      (queue_write),
      .write_data (queue_wdata),
      .full       (queue_full),
      .read       (queue_read),
      .not_empty  (queue_valid),
      .read_data  (queue_rdata)
   );

   ngs_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .POS_BITS    (POS_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_valid      (queue_valid),
      .queue_data       (queue_rdata),
      .queue_read       (queue_read),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_position     (rsp_position),
      .rsp_next_greater (rsp_next_greater),
      .rsp_status       (rsp_status),
      .rsp_run_end      (rsp_run_end)
   );

endmodule

>>> design/ngs_front.sv
// ----------------------------------------------------------------------------
// ngs_front
// Accepts input transactions, tags each with its sequence position and
// writes it into the work queue.
// ----------------------------------------------------------------------------
module ngs_front
   import ngs_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [VALUE_W-1:0]   req_value,
   input  logic                        req_final_item,
   input  logic                        queue_full,
   output logic                        queue_write,
   output logic [VALUE_W+POS_BITS:0]   queue_data
);

   logic [POS_BITS-1:0] next_pos_ff;
   logic [POS_BITS-1:0] next_pos_in;

   assign req_stall   = queue_full;
   assign queue_write = req_valid && !queue_full;
   assign queue_data  = {req_value, req_final_item, next_pos_ff};

   // position restarts after the last element of a sequence
   always_comb begin
      next_pos_in = next_pos_ff;
      if (queue_write) begin
         next_pos_in = req_final_item ? '0 : next_pos_ff + POS_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_pos_ff <= '0;
      end else begin
         next_pos_ff <= next_pos_in;
      end
   end

endmodule

>>> design/ngs_queue.sv
// ----------------------------------------------------------------------------
// ngs_queue
// Small first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
module ngs_queue
   import ngs_pkg::*;
#(
   parameter int WIDTH = VALUE_W + POS_BITS_DEFAULT + 1,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             write,
   input  logic [WIDTH-1:0] write_data,
   output logic             full,
   input  logic             read,
   output logic             not_empty,
   output logic [WIDTH-1:0] read_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_write;
   logic             do_read;

   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign not_empty = (fill_ff != '0);
   assign read_data = entry_ff[rd_ptr_ff];
   assign do_write  = write && !full;
   assign do_read   = read && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_write && !do_read) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_read && !do_write) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         entry_ff[wr_ptr_ff] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> design/ngs_back.sv
// ----------------------------------------------------------------------------
// ngs_back
// Stack sequencer: pops smaller entries, pushes or reports overflow, flushes
// on the last element, and drives the result register.
// ----------------------------------------------------------------------------
module ngs_back
   import ngs_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
   parameter int POS_BITS    = POS_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         queue_valid,
   input  logic [VALUE_W+POS_BITS:0]    queue_data,
   output logic                         queue_read,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [POSITION_W-1:0]        rsp_position,
   output logic signed [VALUE_W-1:0]    rsp_next_greater,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic                         rsp_run_end
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int WORD_W = VALUE_W + POS_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_COMPARE,
      ST_PUSH,
      ST_FLUSH_LOOK,
      ST_FLUSH_EMIT,
      ST_DONE
   } state_type;

   logic [WORD_W-1:0] stack_mem [STACK_DEPTH];

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic signed [VALUE_W-1:0]  cur_value_ff;
   logic                       cur_final_ff;
   logic [POS_BITS-1:0]        cur_pos_ff;
   logic signed [VALUE_W-1:0]  rd_value_ff;
   logic [POS_BITS-1:0]        rd_pos_ff;
   logic                       hold_valid_ff;
   logic [POS_BITS-1:0]        hold_pos_ff;
   logic signed [VALUE_W-1:0]  hold_value_ff;
   status_type                 hold_status_ff;
   logic                       out_valid_ff;
   logic [POSITION_W-1:0]      out_pos_ff;
   logic signed [VALUE_W-1:0]  out_value_ff;
   status_type                 out_status_ff;
   logic                       out_run_end_ff;

   logic                       out_free;
   logic                       emit_new;
   logic                       finish;
   logic [POS_BITS-1:0]        new_pos;
   logic signed [VALUE_W-1:0]  new_value;
   status_type                 new_status;
   logic                       rd_en;
   logic                       wr_en;
   logic [ADDR_W-1:0]          top_addr;
   logic [ADDR_W-1:0]          push_addr;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign top_addr  = ADDR_W'(count_ff - CNT_W'(1));
   assign push_addr = ADDR_W'(count_ff);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      queue_read = 1'b0;
      emit_new   = 1'b0;
      finish     = 1'b0;
      new_pos    = rd_pos_ff;
      new_value  = cur_value_ff;
      new_status = STATUS_FOUND;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            queue_read = queue_valid;
            if (queue_valid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (count_ff == '0) begin
               state_in = ST_PUSH;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (rd_value_ff < cur_value_ff) begin
               if (out_free) begin
                  emit_new = 1'b1;
                  count_in = count_ff - CNT_W'(1);
                  state_in = ST_LOOK;
               end
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (count_ff == CNT_W'(STACK_DEPTH)) begin
               // full stack: this element's answer is lost
               if (out_free) begin
                  emit_new   = 1'b1;
                  new_pos    = cur_pos_ff;
                  new_value  = '0;
                  new_status = STATUS_OVERFLOW;
                  state_in   = cur_final_ff ? ST_FLUSH_LOOK : ST_DONE;
               end
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = cur_final_ff ? ST_FLUSH_LOOK : ST_DONE;
            end
         end
         ST_FLUSH_LOOK: begin
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_FLUSH_EMIT;
            end
         end
         ST_FLUSH_EMIT: begin
            if (out_free) begin
               emit_new   = 1'b1;
               new_value  = '0;
               new_status = STATUS_NONE;
               count_in   = count_ff - CNT_W'(1);
               state_in   = ST_FLUSH_LOOK;
            end
         end
         ST_DONE: begin
            if (out_free || !hold_valid_ff) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[push_addr] <= {cur_value_ff, cur_pos_ff};
      end
      if (rd_en) begin
         {rd_value_ff, rd_pos_ff} <= stack_mem[top_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         // a held result goes out once it is known whether it closes the item
         if (hold_valid_ff && (emit_new || finish)) begin
            out_valid_ff   <= 1'b1;
            out_pos_ff     <= POSITION_W'(hold_pos_ff);
            out_value_ff   <= hold_value_ff;
            out_status_ff  <= hold_status_ff;
            out_run_end_ff <= finish;
         end else if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (emit_new) begin
            hold_valid_ff  <= 1'b1;
            hold_pos_ff    <= new_pos;
            hold_value_ff  <= new_value;
            hold_status_ff <= new_status;
         end else if (finish) begin
            hold_valid_ff <= 1'b0;
         end
         if (queue_read) begin
            {cur_value_ff, cur_final_ff, cur_pos_ff} <= queue_data;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_position     = out_pos_ff;
   assign rsp_next_greater = out_value_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_run_end      = out_run_end_ff;

endmodule

>>> sim/next_greater_element_stack_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// next_greater_element_stack_top_tb
// Drives signed element sequences into the next-greater-element unit and
// checks every answer transaction against a monotonic stack tracker kept in
// the bench. It covers directed edge values and random runs (wide, deep
// enough at times to overflow the stack, narrow with many equal values, and
// open-ended).
// ----------------------------------------------------------------------------
package ngs_tb_pkg;
   import ngs_pkg::*;

   typedef struct packed {
      logic [POSITION_W-1:0]     position;
      logic signed [VALUE_W-1:0] next_greater;
      status_type                status;
      logic                      run_end;
   } answer_type;

   class next_greater_tracker;
      logic signed [VALUE_W-1:0] stack_value [STACK_DEPTH_DEFAULT];
      logic [POSITION_W-1:0]     stack_pos [STACK_DEPTH_DEFAULT];
      int                        depth_used;
      logic [POSITION_W-1:0]     next_pos;
      answer_type                answers_due [$];
      int                        failures;

      function new();
         depth_used = 0;
         next_pos   = '0;
         failures   = 0;
      endfunction

      function void queue_answer(logic [POSITION_W-1:0] pos,
                                 logic signed [VALUE_W-1:0] greater, status_type st);
         answer_type a;
         a.position     = pos;
         a.next_greater = greater;
         a.status       = st;
         a.run_end      = 1'b0;
         answers_due.push_back(a);
      endfunction

      // works out every answer that one accepted element causes
      function void note_element(logic signed [VALUE_W-1:0] value, logic final_item);
         int         already;
         answer_type last;
         already = answers_due.size();
         while (depth_used > 0 && stack_value[depth_used-1] < value) begin
            depth_used--;
            queue_answer(stack_pos[depth_used], value, STATUS_FOUND);
         end
         if (depth_used >= STACK_DEPTH_DEFAULT) begin
            // full stack: this element's answer is lost, its position still used
            queue_answer(next_pos, '0, STATUS_OVERFLOW);
         end else begin
            stack_value[depth_used] = value;
            stack_pos[depth_used]   = next_pos;
            depth_used++;
         end
         next_pos++;
         if (final_item) begin
            while (depth_used > 0) begin
               depth_used--;
               queue_answer(stack_pos[depth_used], '0, STATUS_NONE);
            end
            next_pos = '0;
         end
         if (answers_due.size() > already) begin
            last = answers_due.pop_back();
            last.run_end = 1'b1;
            answers_due.push_back(last);
         end
      endfunction

      function void check_answer(answer_type got);
         answer_type want;
         if (answers_due.size() == 0) begin
            $error("answer with nothing expected: position %0d status %0d",
                   got.position, got.status);
            failures++;
            return;
         end
         want = answers_due.pop_front();
         if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            failures++;
         end
         if (got.next_greater !== want.next_greater) begin
            $error("next_greater: expected %0d, got %0d", want.next_greater,
                   got.next_greater);
            failures++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         if (got.run_end !== want.run_end) begin
            $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
            failures++;
         end
      endfunction

      function int pending();
         return answers_due.size();
      endfunction
   endclass

endpackage

module next_greater_element_stack_top_tb;
   import ngs_pkg::*;
   import ngs_tb_pkg::*;

   typedef enum int {
      RUN_WIDE,
      RUN_DEEP,
      RUN_NARROW,
      RUN_OPEN
   } run_kind_type;

   localparam int RANDOM_ELEMENTS = 360;
   localparam int DRAIN_CYCLES    = 40;

   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value      = '0;
   logic                      req_final_item = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall      = 1'b0;
   logic [POSITION_W-1:0]     rsp_position;
   logic signed [VALUE_W-1:0] rsp_next_greater;
   logic [STATUS_W-1:0]       rsp_status;
   logic                      rsp_run_end;

   bit                  no_idle       = 1'b0;
   int unsigned         stall_left    = 0;
   int                  elements_sent = 0;
   next_greater_tracker tracker       = new();

   always #1 clock = ~clock;

   next_greater_element_stack_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_final_item   (req_final_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_position     (rsp_position),
      .rsp_next_greater (rsp_next_greater),
      .rsp_status       (rsp_status),
      .rsp_run_end      (rsp_run_end)
   );

   // answer side: check each transaction, then raise rsp_stall at random unless no_idle is set
   always @(posedge clock) begin : rsp_side
      int unsigned draw;
      answer_type  got;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         got.position     = rsp_position;
         got.next_greater = rsp_next_greater;
         got.status       = status_type'(rsp_status);
         got.run_end      = rsp_run_end;
         tracker.check_answer(got);
         draw = no_idle ? 0 : $urandom_range(0, 8);
         stall_left <= draw;
         rsp_stall  <= (draw != 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end
   end

   task automatic send_element(input logic signed [VALUE_W-1:0] value,
                               input logic final_item);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_value      <= value;
      req_final_item <= final_item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_element(value, final_item);
      elements_sent++;
   endtask

   task automatic send_run(input run_kind_type kind);
      int                        length;
      int                        i;
      logic signed [VALUE_W-1:0] v;
      case (kind)
         RUN_WIDE: begin
            length = $urandom_range(1, 8);
            for (i = 0; i < length; i++) send_element($urandom, i == length - 1);
         end
         RUN_DEEP: begin
            // non-increasing run of 61 to 69 elements, at times longer than the stack, then a random closer
            length = $urandom_range(62, 70);
            v = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
            for (i = 0; i < length - 1; i++) begin
               send_element(v, 1'b0);
               v = v - $urandom_range(0, 3);
            end
            send_element($urandom, 1'b1);
         end
         RUN_NARROW: begin
            length = $urandom_range(5, 30);
            for (i = 0; i < length; i++) begin
               v = $urandom_range(0, 7) - 4;
               send_element(v, i == length - 1);
            end
         end
         default: begin
            // no final item: the stack carries into the next run
            length = $urandom_range(1, 6);
            for (i = 0; i < length; i++) send_element($urandom, 1'b0);
         end
      endcase
   endtask

   initial begin
      run_kind_type kind;
      int           runs;
      int           random_start;
      int           i;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_element(0, 1'b1);
      send_element(32'h7FFF_FFFF, 1'b0);
      send_element(32'h8000_0000, 1'b0);
      send_element(-1, 1'b0);
      send_element(-1, 1'b0);
      send_element(0, 1'b0);
      send_element(1, 1'b0);
      send_element(32'h7FFF_FFFF, 1'b1);
      for (i = 5; i >= 1; i--) send_element(i, 1'b0);
      send_element(100, 1'b1);
      send_element(32'h8000_0000, 1'b1);

      runs = 0;
      random_start = elements_sent;
      while (elements_sent - random_start < RANDOM_ELEMENTS) begin
         no_idle <= ($urandom_range(0, 5) == 0);
         if (runs == 0) kind = RUN_DEEP;
         else kind = run_kind_type'($urandom_range(0, 3));
         send_run(kind);
         runs++;
      end
      req_valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("PASS next_greater_element_stack_top");
      end else begin
         $display("FAIL next_greater_element_stack_top");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL next_greater_element_stack_top");
      $finish;
   end

endmodule
